@@ rtl/fah_pkg.sv @@
package fah_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_REGIONS  = 64;

    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int OFF_W  = 12;
    localparam int SIZE_W = 13;
    localparam int SUM_W  = 14;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [SIZE_W-1:0] sz_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // One table entry: header offset and payload size
    typedef struct packed {
        off_t start;
        sz_t  size;
    } region_t;

    // Port commands toward one table
    typedef struct packed {
        logic    rd_en;
        idx_t    rd_addr;
        logic    wr_en;
        idx_t    wr_addr;
        region_t wr_data;
    } tbl_cmd_t;

    localparam region_t INIT_REGION = '{start: '0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

endpackage

@@ rtl/fah_if.sv @@
interface fah_req_if;
    import fah_pkg::*;
    logic          valid;
    logic          ready;
    logic          opcode;
    logic [12:0]   request_size;
    logic [11:0]   block_offset;

    modport source (output valid, opcode, request_size, block_offset, input ready);
    modport sink   (input valid, opcode, request_size, block_offset, output ready);
endinterface

interface fah_rsp_if;
    import fah_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [11:0]   payload_offset;
    logic [12:0]   result_size;
    logic          merged_previous;
    logic          merged_following;

    modport source (output valid, status, payload_offset, result_size, merged_previous,
                    merged_following, input ready);
    modport sink   (input valid, status, payload_offset, result_size, merged_previous,
                    merged_following, output ready);
endinterface

@@ rtl/fah_table.sv @@
module fah_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               use_init,
    input  fah_pkg::tbl_cmd_t  cmd,
    output fah_pkg::region_t   rd_data
);
    import fah_pkg::*;

    region_t mem [MAX_REGIONS];
    region_t rd_q_reg;
    logic    fresh_reg;
    logic    rd_fresh_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[cmd.rd_addr];
        end
    end

    // Until its first write, entry zero reads as the initial region when use_init is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg    <= 1'b1;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && cmd.wr_addr == '0)
            begin
                fresh_reg <= 1'b0;
            end
            if (cmd.rd_en)
            begin
                rd_fresh_reg <= use_init && fresh_reg && cmd.rd_addr == '0;
            end
        end
    end

    assign rd_data = rd_fresh_reg ? INIT_REGION : rd_q_reg;

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// Channel  Direction  Transaction
// req      in         opcode, request_size, block_offset
// rsp      out        status, payload_offset, result_size, merged_previous, merged_following
//
// One transaction at a time. An allocate walks the free regions for the first fit; a free
// walks the live blocks for its offset, then the free regions for the insertion point;
// a null free (offset zero) walks nothing, and an unknown one stops after the live walk.
// Using up a region, inserting one or joining both neighbors adds a shift of M entries.
// Each walk reads one entry a cycle from its table.
// Reset needs no clearing pass; entry zero of the free table reads as the whole heap.
// A waiting response stalls only the final state; the next request is taken meanwhile.
module first_fit_heap_allocator (
    input  logic          clk,
    input  logic          rst_n,
    fah_req_if.sink       req,
    fah_rsp_if.source     rsp
);
    import fah_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_A_SCAN, S_F_LSCAN, S_F_FSCAN, S_F_ACT, S_SHIFT, S_L_RD, S_L_WR, S_FIN
    } state_t;

    state_t   state_reg, state_next;
    logic     op_reg, op_next;
    sz_t      size_reg, size_next;
    off_t     off_reg, off_next;
    cnt_t     fcount_reg, fcount_next;
    cnt_t     lcount_reg, lcount_next;
    cnt_t     scan_reg, scan_next;
    logic     chk_valid_reg, chk_valid_next;
    idx_t     chk_idx_reg, chk_idx_next;
    cnt_t     p_reg, p_next;
    idx_t     j_reg, j_next;
    region_t  blk_reg, blk_next;
    region_t  prev_reg, prev_next;
    region_t  cur_reg, cur_next;
    cnt_t     sh_left_reg, sh_left_next;
    idx_t     sh_src_reg, sh_src_next;
    idx_t     sh_dst_reg, sh_dst_next;
    logic     sh_up_reg, sh_up_next;
    logic     sh_pend_reg, sh_pend_next;
    logic     sh_fin_reg, sh_fin_next;
    status_t  res_st_reg, res_st_next;
    off_t     res_off_reg, res_off_next;
    sz_t      res_size_reg, res_size_next;
    logic     res_mp_reg, res_mp_next;
    logic     res_mn_reg, res_mn_next;
    logic     out_valid_reg, out_valid_next;
    status_t  out_st_reg, out_st_next;
    off_t     out_off_reg, out_off_next;
    sz_t      out_size_reg, out_size_next;
    logic     out_mp_reg, out_mp_next;
    logic     out_mn_reg, out_mn_next;

    tbl_cmd_t fcmd, lcmd;
    region_t  frd, lrd;

    fah_table u_free (.clk(clk), .rst_n(rst_n), .use_init(1'b1), .cmd(fcmd), .rd_data(frd));
    fah_table u_live (.clk(clk), .rst_n(rst_n), .use_init(1'b0), .cmd(lcmd), .rd_data(lrd));

    // Compare and arithmetic on the entry just read
    sz_t  diff;
    logic hit_a, hit_l, hit_f, split, mp, mn;
    off_t new_start;
    sz_t  size_both, size_prev, size_next_merge;

    assign diff      = frd.size - size_reg;
    assign hit_a     = frd.size >= size_reg;
    assign split     = diff > SIZE_W'(HEADER_BYTES);
    assign new_start = frd.start + OFF_W'(HEADER_BYTES) + size_reg[OFF_W-1:0];
    assign hit_l     = ({1'b0, lrd.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, off_reg};
    assign hit_f     = frd.start > blk_reg.start;
    assign mp = (p_reg != '0) &&
        (SUM_W'(prev_reg.start) + SUM_W'(HEADER_BYTES) + SUM_W'(prev_reg.size)
         == SUM_W'(blk_reg.start));
    assign mn = (p_reg < fcount_reg) &&
        (SUM_W'(blk_reg.start) + SUM_W'(HEADER_BYTES) + SUM_W'(blk_reg.size)
         == SUM_W'(cur_reg.start));
    assign size_both = SIZE_W'(SUM_W'(prev_reg.size) + SUM_W'(2 * HEADER_BYTES)
                       + SUM_W'(blk_reg.size) + SUM_W'(cur_reg.size));
    assign size_prev = SIZE_W'(SUM_W'(prev_reg.size) + SUM_W'(HEADER_BYTES)
                       + SUM_W'(blk_reg.size));
    assign size_next_merge = SIZE_W'(SUM_W'(cur_reg.size) + SUM_W'(HEADER_BYTES)
                       + SUM_W'(blk_reg.size));

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        fcount_next    = fcount_reg;
        lcount_next    = lcount_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        blk_next       = blk_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        sh_left_next   = sh_left_reg;
        sh_src_next    = sh_src_reg;
        sh_dst_next    = sh_dst_reg;
        sh_up_next     = sh_up_reg;
        sh_pend_next   = sh_pend_reg;
        sh_fin_next    = sh_fin_reg;
        res_st_next    = res_st_reg;
        res_off_next   = res_off_reg;
        res_size_next  = res_size_reg;
        res_mp_next    = res_mp_reg;
        res_mn_next    = res_mn_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_st_next    = out_st_reg;
        out_off_next   = out_off_reg;
        out_size_next  = out_size_reg;
        out_mp_next    = out_mp_reg;
        out_mn_next    = out_mn_reg;
        fcmd           = '0;
        lcmd           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.opcode;
                    size_next      = req.request_size;
                    off_next       = req.block_offset;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    res_st_next    = ST_OK;
                    res_off_next   = '0;
                    res_size_next  = '0;
                    res_mp_next    = 1'b0;
                    res_mn_next    = 1'b0;
                    if (req.opcode == OP_ALLOC)
                    begin
                        state_next = S_A_SCAN;
                    end
                    else if (req.block_offset == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_F_LSCAN;
                    end
                end
            end

            // Walk free regions for the first fit
            S_A_SCAN:
            begin
                if (chk_valid_reg && hit_a)
                begin
                    state_next = S_FIN;
                    if (lcount_reg >= CNT_W'(MAX_REGIONS))
                    begin
                        res_st_next = ST_FULL;
                    end
                    else
                    begin
                        res_off_next  = frd.start + OFF_W'(HEADER_BYTES);
                        lcmd.wr_en    = 1'b1;
                        lcmd.wr_addr  = lcount_reg[IDX_W-1:0];
                        lcmd.wr_data.start = frd.start;
                        lcount_next   = lcount_reg + 1'b1;
                        if (split)
                        begin
                            res_size_next = size_reg;
                            lcmd.wr_data.size = size_reg;
                            fcmd.wr_en    = 1'b1;
                            fcmd.wr_addr  = chk_idx_reg;
                            fcmd.wr_data  = '{start: new_start,
                                              size: diff - SIZE_W'(HEADER_BYTES)};
                        end
                        else
                        begin
                            res_size_next = frd.size;
                            lcmd.wr_data.size = frd.size;
                            fcount_next   = fcount_reg - 1'b1;
                            sh_left_next  = fcount_reg - 1'b1 - CNT_W'(chk_idx_reg);
                            sh_src_next   = chk_idx_reg + 1'b1;
                            sh_up_next    = 1'b0;
                            sh_pend_next  = 1'b0;
                            sh_fin_next   = 1'b0;
                            state_next    = S_SHIFT;
                        end
                    end
                end
                else if (scan_reg >= fcount_reg)
                begin
                    res_st_next = ST_NOSPACE;
                    state_next  = S_FIN;
                end
                else
                begin
                    fcmd.rd_en     = 1'b1;
                    fcmd.rd_addr   = scan_reg[IDX_W-1:0];
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    scan_next      = scan_reg + 1'b1;
                end
            end

            // Walk live blocks for the offset
            S_F_LSCAN:
            begin
                if (chk_valid_reg && hit_l)
                begin
                    j_next         = chk_idx_reg;
                    blk_next       = lrd;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_F_FSCAN;
                end
                else if (scan_reg >= lcount_reg)
                begin
                    res_st_next = ST_UNKNOWN;
                    state_next  = S_FIN;
                end
                else
                begin
                    lcmd.rd_en     = 1'b1;
                    lcmd.rd_addr   = scan_reg[IDX_W-1:0];
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    scan_next      = scan_reg + 1'b1;
                end
            end

            // Walk free regions for the insertion point, keeping the one before
            S_F_FSCAN:
            begin
                if (chk_valid_reg && hit_f)
                begin
                    p_next     = CNT_W'(chk_idx_reg);
                    cur_next   = frd;
                    state_next = S_F_ACT;
                end
                else
                begin
                    if (chk_valid_reg)
                    begin
                        prev_next = frd;
                    end
                    if (scan_reg >= fcount_reg)
                    begin
                        p_next     = fcount_reg;
                        state_next = S_F_ACT;
                    end
                    else
                    begin
                        fcmd.rd_en     = 1'b1;
                        fcmd.rd_addr   = scan_reg[IDX_W-1:0];
                        chk_idx_next   = scan_reg[IDX_W-1:0];
                        chk_valid_next = 1'b1;
                        scan_next      = scan_reg + 1'b1;
                    end
                end
            end

            // Merge or insert the freed block
            S_F_ACT:
            begin
                res_mp_next  = mp;
                res_mn_next  = mn;
                sh_pend_next = 1'b0;
                if (!mp && !mn && fcount_reg >= CNT_W'(MAX_REGIONS))
                begin
                    res_st_next = ST_FULL;
                    res_mp_next = 1'b0;
                    res_mn_next = 1'b0;
                    state_next  = S_FIN;
                end
                else if (mp && mn)
                begin
                    res_size_next = size_both;
                    fcmd.wr_en    = 1'b1;
                    fcmd.wr_addr  = IDX_W'(p_reg - 1'b1);
                    fcmd.wr_data  = '{start: prev_reg.start, size: size_both};
                    fcount_next   = fcount_reg - 1'b1;
                    sh_left_next  = fcount_reg - 1'b1 - p_reg;
                    sh_src_next   = IDX_W'(p_reg + 1'b1);
                    sh_up_next    = 1'b0;
                    sh_fin_next   = 1'b0;
                    state_next    = S_SHIFT;
                end
                else if (mp)
                begin
                    res_size_next = size_prev;
                    fcmd.wr_en    = 1'b1;
                    fcmd.wr_addr  = IDX_W'(p_reg - 1'b1);
                    fcmd.wr_data  = '{start: prev_reg.start, size: size_prev};
                    state_next    = S_L_RD;
                end
                else if (mn)
                begin
                    res_size_next = size_next_merge;
                    fcmd.wr_en    = 1'b1;
                    fcmd.wr_addr  = p_reg[IDX_W-1:0];
                    fcmd.wr_data  = '{start: blk_reg.start, size: size_next_merge};
                    state_next    = S_L_RD;
                end
                else
                begin
                    res_size_next = blk_reg.size;
                    fcount_next   = fcount_reg + 1'b1;
                    sh_left_next  = fcount_reg - p_reg;
                    sh_src_next   = IDX_W'(fcount_reg - 1'b1);
                    sh_up_next    = 1'b1;
                    sh_fin_next   = 1'b1;
                    state_next    = S_SHIFT;
                end
            end

            // Move entries one slot, read and write overlapped
            S_SHIFT:
            begin
                if (sh_pend_reg)
                begin
                    fcmd.wr_en   = 1'b1;
                    fcmd.wr_addr = sh_dst_reg;
                    fcmd.wr_data = frd;
                end
                if (sh_left_reg != '0)
                begin
                    fcmd.rd_en   = 1'b1;
                    fcmd.rd_addr = sh_src_reg;
                    sh_dst_next  = sh_up_reg ? sh_src_reg + 1'b1 : sh_src_reg - 1'b1;
                    sh_src_next  = sh_up_reg ? sh_src_reg - 1'b1 : sh_src_reg + 1'b1;
                    sh_left_next = sh_left_reg - 1'b1;
                    sh_pend_next = 1'b1;
                end
                else
                begin
                    sh_pend_next = 1'b0;
                    if (!sh_pend_reg)
                    begin
                        if (sh_fin_reg)
                        begin
                            fcmd.wr_en   = 1'b1;
                            fcmd.wr_addr = p_reg[IDX_W-1:0];
                            fcmd.wr_data = blk_reg;
                        end
                        state_next = (op_reg == OP_FREE) ? S_L_RD : S_FIN;
                    end
                end
            end

            // Move the last live entry into the freed slot
            S_L_RD:
            begin
                lcount_next  = lcount_reg - 1'b1;
                lcmd.rd_en   = 1'b1;
                lcmd.rd_addr = IDX_W'(lcount_reg - 1'b1);
                state_next   = S_L_WR;
            end

            S_L_WR:
            begin
                lcmd.wr_en   = 1'b1;
                lcmd.wr_addr = j_reg;
                lcmd.wr_data = lrd;
                state_next   = S_FIN;
            end

            // Hand the result to the output register
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_off_next   = res_off_reg;
                    out_size_next  = res_size_reg;
                    out_mp_next    = res_mp_reg;
                    out_mn_next    = res_mn_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcount_reg    <= CNT_W'(1);
            lcount_reg    <= '0;
            chk_valid_reg <= 1'b0;
            sh_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcount_reg    <= fcount_next;
            lcount_reg    <= lcount_next;
            chk_valid_reg <= chk_valid_next;
            sh_pend_reg   <= sh_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        off_reg      <= off_next;
        scan_reg     <= scan_next;
        chk_idx_reg  <= chk_idx_next;
        p_reg        <= p_next;
        j_reg        <= j_next;
        blk_reg      <= blk_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        sh_left_reg  <= sh_left_next;
        sh_src_reg   <= sh_src_next;
        sh_dst_reg   <= sh_dst_next;
        sh_up_reg    <= sh_up_next;
        sh_fin_reg   <= sh_fin_next;
        res_st_reg   <= res_st_next;
        res_off_reg  <= res_off_next;
        res_size_reg <= res_size_next;
        res_mp_reg   <= res_mp_next;
        res_mn_reg   <= res_mn_next;
        out_st_reg   <= out_st_next;
        out_off_reg  <= out_off_next;
        out_size_reg <= out_size_next;
        out_mp_reg   <= out_mp_next;
        out_mn_reg   <= out_mn_next;
    end

    assign req.ready            = (state_reg == S_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_st_reg;
    assign rsp.payload_offset   = out_off_reg;
    assign rsp.result_size      = out_size_reg;
    assign rsp.merged_previous  = out_mp_reg;
    assign rsp.merged_following = out_mn_reg;

endmodule

@@ rtl/fah_checker.sv @@
module fah_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  status,
    input  logic [11:0] payload_offset,
    input  logic [12:0] result_size,
    input  logic        merged_previous,
    input  logic        merged_following
);
    import fah_pkg::*;

    // Stalled response stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped under stall");

    // Accepted request: ready is low in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // Failures carry no offset and no size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> payload_offset == '0 && result_size == '0
            && !merged_previous && !merged_following)
        else $error("failure with nonzero fields");

    // Merge flags only on a successful free
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (merged_previous || merged_following)
            |-> status == ST_OK && payload_offset == '0)
        else $error("merge flag outside a free");

endmodule

bind first_fit_heap_allocator fah_checker u_fah_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .status(rsp.status),
    .payload_offset(rsp.payload_offset),
    .result_size(rsp.result_size),
    .merged_previous(rsp.merged_previous),
    .merged_following(rsp.merged_following)
);
